/* sv/wdpn_pkg.sv */
// ----------------------------------------------------------------------------
// wdpn_pkg
// Shared constants, register indexes and control types of the data presence
// nibbler.
// ----------------------------------------------------------------------------
package wdpn_pkg;

  // Grid limits
  localparam int unsigned MAX_ROWS   = 256;
  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned MAX_RADIUS = 15;

  // Field widths
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned RCNT_W  = 9;
  localparam int unsigned CCNT_W  = 7;
  localparam int unsigned RAD_W   = 4;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1,
    REG_RADIUS    = 2'd2
  } wdpn_reg_e;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [RCNT_W-1:0] row_count;
    logic [CCNT_W-1:0] col_count;
    logic [RAD_W-1:0]  radius;
  } wdpn_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic setup;     // compute window bounds and mask
    logic rd_en;     // read map row at scan pointer
    logic inc;       // advance scan pointer
    logic wr_en;     // write merged row back
    logic out_load;  // capture result into output register
  } wdpn_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic func;      // item is a query
    logic bad;       // address outside grid in use
    logic rad_zero;  // nibbling off
    logic last;      // scan pointer at last window row
  } wdpn_sts_t;

endpackage

/* sv/wdpn_regs.sv */
// ----------------------------------------------------------------------------
// wdpn_regs
// APB configuration registers: row count, column count and radius.
// ----------------------------------------------------------------------------
module wdpn_regs import wdpn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output wdpn_cfg_t          cfg_o
);

  logic [RCNT_W-1:0] row_count_q;
  logic [CCNT_W-1:0] col_count_q;
  logic [RAD_W-1:0]  radius_q;
  logic              wr_en;
  wdpn_reg_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = wdpn_reg_e'(paddr[PADDR_W-1:2]);

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RCNT_W'(MAX_ROWS);
      col_count_q <= CCNT_W'(MAX_COLS);
      radius_q    <= RAD_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW_COUNT: row_count_q <= pwdata[RCNT_W-1:0];
        REG_COL_COUNT: col_count_q <= pwdata[CCNT_W-1:0];
        REG_RADIUS:    radius_q    <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_ROW_COUNT: prdata = PDATA_W'(row_count_q);
      REG_COL_COUNT: prdata = PDATA_W'(col_count_q);
      REG_RADIUS:    prdata = PDATA_W'(radius_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.row_count = row_count_q;
  assign cfg_o.col_count = col_count_q;
  assign cfg_o.radius    = radius_q;

endmodule

/* sv/wdpn_dp.sv */
// ----------------------------------------------------------------------------
// wdpn_dp
// Datapath: item registers, data map memory with row valid bits, window
// bounds, scan pointer, hit accumulator and output payload register.
// ----------------------------------------------------------------------------
module wdpn_dp import wdpn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wdpn_cfg_t        cfg_i,
  input  logic             func_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [COL_W-1:0] col_i,
  input  logic             has_data_i,
  input  wdpn_cmd_t        cmd_i,
  output wdpn_sts_t        sts_o,
  output logic             was_query_o,
  output logic             clear_interpolated_o,
  output logic             bad_address_o
);

  // Item registers
  logic             func_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             data_q;

  // Map storage
  logic [WORD_W-1:0] mem_q [MAX_ROWS];
  logic [MAX_ROWS-1:0] vld_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvld_q;
  logic              rd_pend_q;

  // Window state
  logic [ROW_W-1:0]  k_q;
  logic [ROW_W-1:0]  up_q;
  logic [WORD_W-1:0] mask_q;
  logic              hit_q;

  // Output payload
  logic was_query_q;
  logic clr_q;
  logic bad_q;

  // Combinational helpers
  logic [RCNT_W-1:0] rows;
  logic [CCNT_W-1:0] cols;
  logic              bad;
  logic              rad_zero;
  logic [ROW_W-1:0]  dn;
  logic [RCNT_W-1:0] up_sum;
  logic [ROW_W-1:0]  up;
  logic [COL_W-1:0]  bw;
  logic [CCNT_W-1:0] fw_sum;
  logic [CCNT_W-1:0] fw;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] rword;
  logic [WORD_W-1:0] wword;

  // Grid in use and address check
  assign rows = (cfg_i.row_count > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : cfg_i.row_count;
  assign cols = (cfg_i.col_count > CCNT_W'(MAX_COLS)) ? CCNT_W'(MAX_COLS) : cfg_i.col_count;
  assign bad  = (RCNT_W'(row_q) >= rows) || (CCNT_W'(col_q) >= cols);
  assign rad_zero = (cfg_i.radius == '0);

  // Window bounds, clipped at the grid edges
  always_comb begin
    dn     = (row_q >= ROW_W'(cfg_i.radius)) ? row_q - ROW_W'(cfg_i.radius) : '0;
    up_sum = RCNT_W'(row_q) + RCNT_W'(cfg_i.radius);
    up     = (up_sum < rows) ? up_sum[ROW_W-1:0] : ROW_W'(rows - RCNT_W'(1));
    bw     = (col_q >= COL_W'(cfg_i.radius)) ? col_q - COL_W'(cfg_i.radius) : '0;
    fw_sum = CCNT_W'(col_q) + CCNT_W'(cfg_i.radius);
    fw     = (fw_sum < cols) ? fw_sum : cols - CCNT_W'(1);
    for (int i = 0; i < WORD_W; i++) begin
      mask[i] = (CCNT_W'(i) >= CCNT_W'(bw)) && (CCNT_W'(i) <= fw);
    end
  end

  // Unwritten rows read as empty
  assign rword = rvld_q ? rdata_q : '0;

  // Merge the written data bit
  always_comb begin
    wword        = rword;
    wword[col_q] = data_q;
  end

  // Capture item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      row_q  <= row_i;
      col_q  <= col_i;
      data_q <= has_data_i;
    end
  end

  // Window setup and scan pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      k_q    <= (func_q == FUNC_QUERY) ? dn : row_q;
      up_q   <= up;
      mask_q <= mask;
    end else if (cmd_i.inc) begin
      k_q <= k_q + ROW_W'(1);
    end
  end

  // Hit accumulator over the rows read back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
      if (cmd_i.setup) begin
        hit_q <= 1'b0;
      end else if (rd_pend_q) begin
        hit_q <= hit_q | (|(rword & mask_q));
      end
    end
  end

  // Map memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[k_q];
    end
    if (cmd_i.wr_en) begin
      mem_q[row_q] <= wword;
    end
  end

  // Row valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rvld_q <= vld_q[k_q];
      end
      if (cmd_i.wr_en) begin
        vld_q[row_q] <= 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      was_query_q <= func_q;
      bad_q       <= bad;
      clr_q       <= (func_q == FUNC_QUERY) && !bad && !rad_zero && !hit_q;
    end
  end

  assign was_query_o          = was_query_q;
  assign clear_interpolated_o = clr_q;
  assign bad_address_o        = bad_q;

  assign sts_o.func     = (func_q == FUNC_QUERY);
  assign sts_o.bad      = bad;
  assign sts_o.rad_zero = rad_zero;
  assign sts_o.last     = (k_q == up_q);

endmodule

/* sv/wdpn_ctrl.sv */
// ----------------------------------------------------------------------------
// wdpn_ctrl
// Controller: sequences item capture, window scan or read-modify-write,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module wdpn_ctrl import wdpn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  wdpn_sts_t sts_i,
  output wdpn_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_FLUSH = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } wdpn_state_e;

  wdpn_state_e state_q, state_d;
  logic        out_valid_q;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (sts_i.bad) begin
          state_d = ST_DONE;
        end else if (sts_i.func) begin
          state_d = sts_i.rad_zero ? ST_DONE : ST_SCAN;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.inc   = 1'b1;
        if (sts_i.last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_DONE;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/window_data_presence_nibbler.sv */
// A write reads and rewrites its map row; a query inside the grid scans the rows of its window,
// one map row per cycle, fewer rows where the window is clipped.
// Bad addresses and queries with radius zero skip the map and go straight to the result.
// One item at a time: a new item is taken only once the last result is in the output register.
// Reset clears the data map through per-row valid bits, and restores
// row_count 256, col_count 64, radius 1; the block is ready right after reset.
// ----------------------------------------------------------------------------
// window_data_presence_nibbler
// Top level: grid map of data bits with square-window emptiness queries.
// ----------------------------------------------------------------------------
module window_data_presence_nibbler import wdpn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [ROW_W-1:0]   row_i,
  input  logic [COL_W-1:0]   col_i,
  input  logic               has_data_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               was_query_o,
  output logic               clear_interpolated_o,
  output logic               bad_address_o
);

  wdpn_cfg_t cfg;
  wdpn_cmd_t cmd;
  wdpn_sts_t sts;

  wdpn_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wdpn_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .func_i               (func_i),
    .row_i                (row_i),
    .col_i                (col_i),
    .has_data_i           (has_data_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .was_query_o          (was_query_o),
    .clear_interpolated_o (clear_interpolated_o),
    .bad_address_o        (bad_address_o)
  );

  wdpn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

endmodule

/* sv/wdpn_checker.sv */
// ----------------------------------------------------------------------------
// wdpn_checker
// Port-level checks of the nibbler, bound to the top level.
// ----------------------------------------------------------------------------
module wdpn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic was_query_o,
  input logic clear_interpolated_o,
  input logic bad_address_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(was_query_o)
      && $stable(clear_interpolated_o) && $stable(bad_address_o))
    else $error("stalled result changed");

  // Only a query may clear the interpolated mark
  a_clr_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_interpolated_o |-> was_query_o)
    else $error("clear on a write result");

  // A bad address never clears
  a_clr_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_address_o |-> !clear_interpolated_o)
    else $error("clear on a bad address");

  // Not ready again in the cycle after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while busy");

endmodule

bind window_data_presence_nibbler wdpn_checker u_wdpn_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .was_query_o          (was_query_o),
  .clear_interpolated_o (clear_interpolated_o),
  .bad_address_o        (bad_address_o)
);

/* sim/tb_window_data_presence_nibbler.sv */
// ----------------------------------------------------------------------------
// tb_window_data_presence_nibbler
// Self-checking testbench: drives write and query items with random idle gaps
// and output stalls, predicts every result from a bit-level copy of the data
// map and the grid settings, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_window_data_presence_nibbler;
  import wdpn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest query latency plus margin; used when draining before a register write
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_RADIUS + 12;
  localparam int unsigned PHASE_ITEMS  = 117;
  // Register slot past the defined ones; writes there must be ignored
  localparam logic [1:0]  REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic was_query;
    logic clear_interp;
    logic bad_address;
  } nib_result_t;

  // Scoreboard: holds a copy of the map and the settings, queues predictions
  class presence_scoreboard;
    logic [WORD_W-1:0] grid [MAX_ROWS];
    logic [RCNT_W-1:0] row_count;
    logic [CCNT_W-1:0] col_count;
    logic [RAD_W-1:0]  radius;
    nib_result_t       pending_results [$];
    int unsigned       errors;

    function new();
      foreach (grid[i]) grid[i] = '0;
      row_count = RCNT_W'(256);
      col_count = CCNT_W'(64);
      radius    = RAD_W'(1);
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_ROW_COUNT: row_count = value[RCNT_W-1:0];
        REG_COL_COUNT: col_count = value[CCNT_W-1:0];
        REG_RADIUS:    radius    = value[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned rows_in_use();
      return (row_count < MAX_ROWS) ? row_count : MAX_ROWS;
    endfunction

    function int unsigned cols_in_use();
      return (col_count < MAX_COLS) ? col_count : MAX_COLS;
    endfunction

    // Apply one accepted item to the map and queue its expected result
    function void note_item(logic func, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic data_bit);
      nib_result_t exp_r;
      int unsigned rows, cols, rad, dn, up, bw, fw;
      bit bad, hit;
      rows = rows_in_use();
      cols = cols_in_use();
      bad  = (row >= rows) || (col >= cols);
      exp_r.was_query    = func;
      exp_r.clear_interp = 1'b0;
      exp_r.bad_address  = bad;
      if (!bad) begin
        if (func == FUNC_WRITE) begin
          grid[row][col] = data_bit;
        end else begin
          rad = (radius < MAX_RADIUS) ? radius : MAX_RADIUS;
          if (rad != 0 && !grid[row][col]) begin
            dn  = (row >= rad) ? row - rad : 0;
            up  = (row + rad < rows) ? row + rad : rows - 1;
            bw  = (col >= rad) ? col - rad : 0;
            fw  = (col + rad < cols) ? col + rad : cols - 1;
            hit = 1'b0;
            for (int k = dn; k <= up; k++)
              for (int c = bw; c <= fw; c++)
                if (grid[k][c]) hit = 1'b1;
            exp_r.clear_interp = !hit;
          end
        end
      end
      pending_results.push_back(exp_r);
    endfunction

    // Compare one accepted result against the oldest prediction
    function void check_result(nib_result_t got);
      nib_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %b (was_query/clear/bad), none pending",
                 $time, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.was_query !== exp_r.was_query) begin
        $display("%0t: was_query expected %b actual %b", $time,
                 exp_r.was_query, got.was_query);
        errors++;
      end
      if (got.clear_interp !== exp_r.clear_interp) begin
        $display("%0t: clear_interpolated expected %b actual %b", $time,
                 exp_r.clear_interp, got.clear_interp);
        errors++;
      end
      if (got.bad_address !== exp_r.bad_address) begin
        $display("%0t: bad_address expected %b actual %b", $time,
                 exp_r.bad_address, got.bad_address);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               func_i;
  logic [ROW_W-1:0]   row_i;
  logic [COL_W-1:0]   col_i;
  logic               has_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               was_query_o;
  logic               clear_interpolated_o;
  logic               bad_address_o;

  presence_scoreboard sb;
  bit                 calm;
  int unsigned        stall_left;

  window_data_presence_nibbler dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .func_i               (func_i),
    .row_i                (row_i),
    .col_i                (col_i),
    .has_data_i           (has_data_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .was_query_o          (was_query_o),
    .clear_interpolated_o (clear_interpolated_o),
    .bad_address_o        (bad_address_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #6ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{was_query_o, clear_interpolated_o, bad_address_o});
  end

  // Output back-pressure: random stalls, mostly short, a few long
  initial begin
    int unsigned r;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        out_ready_i = 1'b1;
        stall_left  = 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i = 1'b1;
          stall_left  = $urandom_range(0, 5);
        end else if (r < 92) begin
          out_ready_i = 1'b0;
          stall_left  = $urandom_range(0, 3);
        end else begin
          out_ready_i = 1'b0;
          stall_left  = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(logic func, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic data_bit);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i     = func;
    row_i      = row;
    col_i      = col;
    has_data_i = data_bit;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(func, row, col, data_bit);
  endtask

  // Drop valid and wait until every expected result is back and the block is quiet
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write through the configuration port, only while the block is idle
  task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_grid(int unsigned rows, int unsigned cols, int unsigned rad);
    reg_write(REG_ROW_COUNT, rows);
    reg_write(REG_COL_COUNT, cols);
    reg_write(REG_RADIUS, rad);
  endtask

  // Random item, mostly inside the grid in use, sometimes anywhere
  task automatic send_random_item();
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    int unsigned      rows, cols;
    rows = sb.rows_in_use();
    cols = sb.cols_in_use();
    if (rows != 0 && $urandom_range(0, 99) < 88) row = ROW_W'($urandom_range(0, rows - 1));
    else row = ROW_W'($urandom_range(0, 2**ROW_W - 1));
    if (cols != 0 && $urandom_range(0, 99) < 88) col = COL_W'($urandom_range(0, cols - 1));
    else col = COL_W'($urandom_range(0, 2**COL_W - 1));
    send_item($urandom_range(0, 1) ? FUNC_QUERY : FUNC_WRITE, row, col,
              $urandom_range(0, 99) < 40);
  endtask

  task automatic run_phase();
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_random_item();
      // Now and then let the pipeline run dry
      if ($urandom_range(0, 59) == 0) wait_idle();
    end
  endtask

  // Main sequence
  initial begin
    sb         = new();
    calm       = 1'b0;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    func_i     = FUNC_WRITE;
    row_i      = '0;
    col_i      = '0;
    has_data_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Corners and neighbors on the full grid, radius 1
    send_item(FUNC_QUERY, 8'd0, 6'd0, 1'b1);
    send_item(FUNC_WRITE, 8'd0, 6'd0, 1'b1);
    send_item(FUNC_QUERY, 8'd1, 6'd1, 1'b0);
    send_item(FUNC_QUERY, 8'd0, 6'd0, 1'b0);
    send_item(FUNC_QUERY, 8'd2, 6'd2, 1'b1);
    send_item(FUNC_WRITE, 8'd255, 6'd63, 1'b1);
    send_item(FUNC_QUERY, 8'd254, 6'd62, 1'b0);
    send_item(FUNC_QUERY, 8'd253, 6'd63, 1'b0);
    send_item(FUNC_WRITE, 8'd255, 6'd63, 1'b0);
    send_item(FUNC_QUERY, 8'd255, 6'd63, 1'b0);

    // Shrunken grid: addresses past the edge are rejected, window clips
    set_grid(10, 5, 1);
    send_item(FUNC_WRITE, 8'd10, 6'd0, 1'b1);
    send_item(FUNC_QUERY, 8'd0, 6'd5, 1'b0);
    send_item(FUNC_WRITE, 8'd200, 6'd40, 1'b1);
    send_item(FUNC_QUERY, 8'd9, 6'd4, 1'b0);

    // Nibbling off
    reg_write(REG_RADIUS, 0);
    send_item(FUNC_QUERY, 8'd5, 6'd2, 1'b0);

    // Widest window on the full grid
    set_grid(256, 64, 15);
    send_item(FUNC_QUERY, 8'd128, 6'd32, 1'b0);
    send_item(FUNC_QUERY, 8'd15, 6'd15, 1'b0);

    // Zero counts make every address bad
    reg_write(REG_ROW_COUNT, 0);
    send_item(FUNC_QUERY, 8'd0, 6'd0, 1'b0);
    send_item(FUNC_WRITE, 8'd0, 6'd1, 1'b1);
    reg_write(REG_ROW_COUNT, 511);
    reg_write(REG_COL_COUNT, 0);
    send_item(FUNC_WRITE, 8'd3, 6'd3, 1'b1);

    // Oversized counts saturate at the grid limits
    reg_write(REG_COL_COUNT, 127);
    send_item(FUNC_WRITE, 8'd255, 6'd63, 1'b1);
    send_item(FUNC_QUERY, 8'd240, 6'd48, 1'b0);

    // Write to an unmapped register leaves the settings alone
    reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_item(FUNC_QUERY, 8'd0, 6'd0, 1'b1);

    // Random phases over several grid settings
    set_grid(256, 64, 1);
    run_phase();
    calm = 1'b1;
    set_grid(1, 1, 15);
    run_phase();
    calm = 1'b0;
    set_grid(256, 64, 15);
    run_phase();
    set_grid($urandom_range(1, 40), $urandom_range(1, 16), $urandom_range(0, 15));
    run_phase();
    set_grid($urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 15));
    run_phase();
    set_grid($urandom_range(8, 32), 64, $urandom_range(1, 4));
    run_phase();

    // Drain and report
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
